// ===== hdl/lrn_pkg.sv =====
// Package for the cross-channel LRN block: beat types, config struct,
// sequencer states, ring arithmetic helpers and the exp2 fraction ROM.
// No dependencies.
`default_nettype none

package lrn_pkg;

  localparam int WINDOW_MAX  = 9;
  localparam int SAMPLE_BITS = 16;
  localparam int CHANNEL_MAX = 4096;
  localparam int RESULT_CAP  = 5;

  localparam int CH_W    = $clog2(CHANNEL_MAX);
  localparam int RING_AW = $clog2(WINDOW_MAX);
  localparam int WIN_W   = 4;
  localparam int SUM_W   = 40;
  localparam int NRM_W   = 41;
  localparam int SQ_W    = 2 * SAMPLE_BITS;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_ALPHA  = 2'd1;
  localparam logic [1:0] REG_BETA   = 2'd2;
  localparam logic [1:0] REG_KAPPA  = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_channel;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic               saturated;
    logic               last_of_position;
  } out_beat_t;

  typedef struct packed {
    logic [WIN_W-1:0] window_size;
    logic [31:0]      alpha_scale;
    logic [15:0]      beta_exponent;
    logic [31:0]      kappa_bias;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ISQ, S_IWR, S_CHECK,
    S_E0, S_E1, S_E2, S_NORM,
    S_LSQ, S_LACC, S_BETA, S_BACC,
    S_EXP, S_EXPACC, S_PROD, S_RND, S_EDRP
  } seq_state_e;

  typedef logic [15:0][31:0] rom_t;

  // (p - d) mod WINDOW_MAX for p < WINDOW_MAX, d <= WINDOW_MAX
  function automatic logic [RING_AW-1:0] ring_sub(logic [RING_AW-1:0] p,
                                                  logic [RING_AW-1:0] d);
    logic [RING_AW:0] s;
    s = {1'b0, p} + (RING_AW+1)'(WINDOW_MAX) - {1'b0, d};
    if (s >= (RING_AW+1)'(WINDOW_MAX)) s = s - (RING_AW+1)'(WINDOW_MAX);
    return s[RING_AW-1:0];
  endfunction

  function automatic logic [RING_AW-1:0] ring_inc(logic [RING_AW-1:0] p);
    return (p == RING_AW'(WINDOW_MAX - 1)) ? '0 : p + RING_AW'(1);
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r, b, x;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    x = v;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // entry k = 2^(2^-(k+1)) in Q1.30
  function automatic rom_t build_rom();
    rom_t t;
    logic [63:0] s;
    t = '0;
    s = isqrt64(64'd1 << 61);
    t[0] = s[31:0];
    for (int k = 1; k < 16; k++) begin
      s = isqrt64({32'd0, t[k-1]} << 30);
      t[k] = s[31:0];
    end
    return t;
  endfunction

  localparam rom_t EXP_ROM = build_rom();

endpackage

`default_nettype wire

// ===== hdl/cross_channel_lrn_unit.sv =====
// Cross-channel LRN, top level: APB register file and the sequencer core.
// Depends on lrn_pkg and lrn_core.
// Each input beat passes through accept, square, ring write and check; each result
// then takes up to 40 normalize shifts, 16 log2 squarings and up to 16 exp2
// multiplies, with all squarings and multiplies on one shared multiplier, and
// waits while the output is stalled; up to 5 results per beat on the last channel.
// One beat in flight at a time. Reset clears control state and loads the
// register defaults; the rings need no clearing.
`default_nettype none

module cross_channel_lrn_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire lrn_pkg::in_beat_t in_beat_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output lrn_pkg::out_beat_t     out_beat_o
);
  import lrn_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        REG_WINDOW: cfg_d.window_size = pwdata[WIN_W-1:0];
        REG_ALPHA:  cfg_d.alpha_scale = pwdata;
        REG_BETA:   cfg_d.beta_exponent = pwdata[15:0];
        REG_KAPPA:  cfg_d.kappa_bias = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WINDOW: prdata = 32'(cfg_q.window_size);
      REG_ALPHA:  prdata = cfg_q.alpha_scale;
      REG_BETA:   prdata = 32'(cfg_q.beta_exponent);
      REG_KAPPA:  prdata = cfg_q.kappa_bias;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_size <= WIN_W'(5);
      cfg_q.alpha_scale <= 32'd429497;
      cfg_q.beta_exponent <= 16'd3072;
      cfg_q.kappa_bias <= 32'd65536;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lrn_core u_core (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i, .in_ready_o, .in_beat_i,
    .out_valid_o, .out_ready_i, .out_beat_o
  );

  // a beat is taken only from idle, so ready drops right after
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an accepted beat");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.saturated |->
      (out_beat_o.out_value == 16'sh7fff) || (out_beat_o.out_value == -16'sh8000))
    else $error("saturated flag without a clipped value");

  a_cfg_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(psel && penable && pwrite) |=> $stable(cfg_q))
    else $error("config changed without a write");

endmodule

`default_nettype wire

// ===== hdl/lrn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lrn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 9
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/lrn_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// No dependencies.
`default_nettype none

module lrn_mul (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic [63:0]      p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= {32'd0, a_i} * {32'd0, b_i};
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== hdl/lrn_core.sv =====
// Sequencer and datapath of the LRN block: sample/square rings, window sum,
// log2 / exp2 power and output rounding, with every multiply on one shared multiplier.
// Depends on lrn_pkg, lrn_ram, lrn_mul.
`default_nettype none

module lrn_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lrn_pkg::cfg_t    cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire lrn_pkg::in_beat_t in_beat_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output lrn_pkg::out_beat_t    out_beat_o
);
  import lrn_pkg::*;

  seq_state_e state_q, state_d;

  logic [CH_W-1:0]     ch_q, ch_d, em_q, em_d;
  logic [RING_AW-1:0]  wp_q, wp_d, ep_q, ep_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [2:0]          cnt_q, cnt_d;
  logic                last_q, last_d;
  logic signed [SAMPLE_BITS-1:0] x_q, x_d;
  logic                neg_q, neg_d;
  logic [SAMPLE_BITS-1:0] xe_q, xe_d;
  logic [31:0]         wlo_q, wlo_d;
  logic [NRM_W-1:0]    nrm_q, nrm_d;
  logic [5:0]          c_q, c_d, e_q, e_d;
  logic [31:0]         m_q, m_d;
  logic [15:0]         frac_q, frac_d;
  logic [3:0]          j_q, j_d;
  logic signed [39:0]  e28_q, e28_d;
  logic                out_valid_q, out_valid_d;
  out_beat_t           out_q, out_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        s_we;
  logic [RING_AW-1:0] q_raddr;
  logic [SAMPLE_BITS-1:0] s_rdata;
  logic [SQ_W-1:0] q_rdata;

  // window geometry
  logic [WIN_W-1:0] size;
  logic [WIN_W-1:0] half, lo;
  always_comb begin
    if (cfg_i.window_size == '0) size = WIN_W'(1);
    else if (cfg_i.window_size > WIN_W'(WINDOW_MAX)) size = WIN_W'(WINDOW_MAX);
    else size = cfg_i.window_size;
    half = size >> 1;
    lo   = (size - WIN_W'(1)) >> 1;
  end

  logic [SAMPLE_BITS-1:0] x_abs;
  assign x_abs = x_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_q) : SAMPLE_BITS'(x_q);

  logic emit_go, out_free;
  assign emit_go = ((cnt_q == 3'd0) && ({1'b0, em_q} + (CH_W+1)'(half) <= {1'b0, ch_q}))
                 || (last_q && (em_q <= ch_q) && (cnt_q < 3'(RESULT_CAP)));
  assign out_free = !out_valid_q || out_ready_i;

  // log2 value magnitude and sign
  logic        l_pos;
  logic [21:0] l_mag;
  assign l_pos = e_q >= 6'd16;
  assign l_mag = l_pos ? {e_q - 6'd16, frac_q}
                       : ({6'd16 - e_q, 16'd0} - {6'd0, frac_q});

  logic [15:0] f_bits;
  logic        f_bit;
  assign f_bits = e28_q[27:12];
  assign f_bit  = f_bits[4'd15 - j_q];

  assign q_raddr = (state_q == S_ISQ) ? ring_sub(wp_q, size) : ring_sub(ep_q, lo);

  lrn_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_sample_ring (
    .clk_i, .we_i(s_we), .waddr_i(wp_q), .wdata_i(x_q),
    .raddr_i(ep_q), .rdata_o(s_rdata)
  );

  lrn_ram #(.WIDTH(SQ_W), .DEPTH(WINDOW_MAX)) u_square_ring (
    .clk_i, .we_i(s_we), .waddr_i(wp_q), .wdata_i(prod[SQ_W-1:0]),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  lrn_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(prod));

  // operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_ISQ: begin
        mul_a = 32'(x_abs);
        mul_b = 32'(x_abs);
      end
      S_E0: begin
        mul_a = cfg_i.alpha_scale;
        mul_b = sum_q[31:0];
      end
      S_E1: begin
        mul_a = cfg_i.alpha_scale;
        mul_b = 32'(sum_q[SUM_W-1:32]);
      end
      S_LSQ: begin
        mul_a = m_q;
        mul_b = m_q;
      end
      S_BETA: begin
        mul_a = 32'(cfg_i.beta_exponent);
        mul_b = 32'(l_mag);
      end
      S_EXP: begin
        mul_a = m_q;
        mul_b = EXP_ROM[j_q];
      end
      S_PROD: begin
        mul_a = 32'(xe_q);
        mul_b = m_q;
      end
      default: ;
    endcase
  end

  // rounding and saturation
  logic signed [11:0] q_exp;
  logic signed [12:0] sh;
  logic [47:0]        pmag, shr;
  logic [48:0]        mag;
  logic               sat;
  out_beat_t          res;
  always_comb begin
    q_exp = e28_q[39:28];
    sh    = 13'sd30 - 13'(q_exp);
    pmag  = prod[47:0];
    shr   = '0;
    sat   = 1'b0;
    mag   = '0;
    if (pmag == '0) begin
      mag = '0;
    end else if (sh <= 13'sd0) begin
      sat = 1'b1;
    end else if (sh > 13'sd48) begin
      mag = '0;
    end else begin
      shr = pmag >> (6'(sh) - 6'd1);
      mag = ({1'b0, shr} + 49'd1) >> 1;
    end
    res.last_of_position = last_q && (em_q == ch_q);
    if (neg_q) begin
      if (sat || mag > 49'd32768) begin
        mag = 49'd32768;
        sat = 1'b1;
      end
      res.out_value = -$signed(mag[15:0]);
    end else begin
      if (sat || mag > 49'd32767) begin
        mag = 49'd32767;
        sat = 1'b1;
      end
      res.out_value = $signed(mag[15:0]);
    end
    res.saturated = sat;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_ISQ;
      S_ISQ:    state_d = S_IWR;
      S_IWR:    state_d = S_CHECK;
      S_CHECK:  state_d = emit_go ? S_E0 : S_IDLE;
      S_E0:     state_d = S_E1;
      S_E1:     state_d = S_E2;
      S_E2:     state_d = S_NORM;
      S_NORM:   if (nrm_q[NRM_W-1]) state_d = S_LSQ;
      S_LSQ:    state_d = S_LACC;
      S_LACC:   state_d = (j_q == 4'd15) ? S_BETA : S_LSQ;
      S_BETA:   state_d = S_BACC;
      S_BACC:   state_d = S_EXP;
      S_EXP: begin
        if (f_bit) state_d = S_EXPACC;
        else if (j_q == 4'd15) state_d = S_PROD;
      end
      S_EXPACC: state_d = (j_q == 4'd15) ? S_PROD : S_EXP;
      S_PROD:   state_d = S_RND;
      S_RND: begin
        if (out_free) begin
          state_d = (last_q && em_q >= CH_W'(lo)) ? S_EDRP : S_CHECK;
        end
      end
      S_EDRP:   state_d = S_CHECK;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath
  logic [NRM_W-1:0] norm;
  logic [31:0]      mm;
  always_comb begin
    ch_d = ch_q;   em_d = em_q;   wp_d = wp_q;   ep_d = ep_q;
    sum_d = sum_q; cnt_d = cnt_q; last_d = last_q; x_d = x_q;
    neg_d = neg_q; xe_d = xe_q;   wlo_d = wlo_q; nrm_d = nrm_q;
    c_d = c_q;     e_d = e_q;     m_d = m_q;     frac_d = frac_q;
    j_d = j_q;     e28_d = e28_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    s_we = 1'b0;
    norm = '0;
    mm = prod[61:30];
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        x_d = in_beat_i.sample;
        last_d = in_beat_i.last_channel || (ch_q == CH_W'(CHANNEL_MAX - 1));
        cnt_d = '0;
      end
      S_IWR: begin
        s_we = 1'b1;
        sum_d = sum_q + SUM_W'(prod[SQ_W-1:0])
              - ((ch_q >= CH_W'(size)) ? SUM_W'(q_rdata) : '0);
      end
      S_CHECK: begin
        if (!emit_go) begin
          if (last_q) begin
            ch_d = '0; em_d = '0; wp_d = '0; ep_d = '0; sum_d = '0;
          end else begin
            ch_d = ch_q + CH_W'(1);
            wp_d = ring_inc(wp_q);
          end
        end
      end
      S_E1: begin
        neg_d = s_rdata[SAMPLE_BITS-1];
        xe_d = s_rdata[SAMPLE_BITS-1] ? -s_rdata : s_rdata;
        wlo_d = prod[63:32];
      end
      S_E2: begin
        norm = NRM_W'(cfg_i.kappa_bias) + NRM_W'(wlo_q) + NRM_W'(prod[39:0]);
        nrm_d = (norm == '0) ? NRM_W'(1) : norm;
        c_d = '0;
      end
      S_NORM: begin
        if (nrm_q[NRM_W-1]) begin
          m_d = 32'(nrm_q[NRM_W-1:10]);
          e_d = 6'd40 - c_q;
          frac_d = '0;
          j_d = '0;
        end else begin
          nrm_d = nrm_q << 1;
          c_d = c_q + 6'd1;
        end
      end
      S_LACC: begin
        m_d = mm[31] ? (mm >> 1) : mm;
        frac_d = {frac_q[14:0], mm[31]};
        j_d = j_q + 4'd1;
      end
      S_BACC: begin
        e28_d = l_pos ? -$signed({2'b00, prod[37:0]}) : $signed({2'b00, prod[37:0]});
        m_d = 32'd1 << 30;
        j_d = '0;
      end
      S_EXP: begin
        if (!f_bit && j_q != 4'd15) j_d = j_q + 4'd1;
      end
      S_EXPACC: begin
        m_d = mm;
        if (j_q != 4'd15) j_d = j_q + 4'd1;
      end
      S_RND: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = res;
          em_d = em_q + CH_W'(1);
          ep_d = ring_inc(ep_q);
          cnt_d = cnt_q + 3'd1;
        end
      end
      S_EDRP: begin
        sum_d = sum_q - SUM_W'(q_rdata);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q <= '0;
      em_q <= '0;
      wp_q <= '0;
      ep_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
      last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q <= ch_d;
      em_q <= em_d;
      wp_q <= wp_d;
      ep_q <= ep_d;
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      last_q <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    neg_q <= neg_d;
    xe_q <= xe_d;
    wlo_q <= wlo_d;
    nrm_q <= nrm_d;
    c_q <= c_d;
    e_q <= e_d;
    m_q <= m_d;
    frac_q <= frac_d;
    j_q <= j_d;
    e28_q <= e28_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o = out_q;

endmodule

`default_nettype wire

// ===== tb/sv/lrn_checker.sv =====
// Self-checking monitor for the cross-channel LRN block: follows APB writes,
// predicts normalized outputs for every accepted input beat and compares them.
// Depends on lrn_pkg for beat types, register indexes and sizes.
module lrn_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic               pready,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire lrn_pkg::in_beat_t  in_beat_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire lrn_pkg::out_beat_t out_beat_i,
  output int                      pending_o,
  output int                      errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import lrn_pkg::*;

  logic [31:0]             exp2_frac [16];
  logic signed [15:0]      sample_hist [WINDOW_MAX];
  logic [31:0]             square_hist [WINDOW_MAX];
  logic [39:0]             square_total;
  int unsigned             chan_cnt;
  int unsigned             done_cnt;
  logic [3:0]              cfg_window;
  logic [31:0]             cfg_alpha;
  logic [15:0]             cfg_beta;
  logic [31:0]             cfg_kappa;
  out_beat_t               expected_norm_q [$];

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // log2 of a Q16.16 value, result in Q.16
  function automatic longint log2_q16(longint unsigned n);
    int unsigned     e;
    longint unsigned t, m;
    longint          frac;
    e = 0;
    t = n;
    while (t > 1) begin
      t = t >> 1;
      e++;
    end
    m = (e <= 30) ? (n << (30 - e)) : (n >> (e - 30));
    frac = 0;
    for (int j = 0; j < 16; j++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (longint'(e) - 16) * 65536 + frac;
  endfunction

  function automatic out_beat_t normalize_channel(int unsigned k, bit last_flag);
    longint unsigned s, al, ah, weighted, norm, biased, f, m, prod, mag, xm;
    longint          e_q28, q, sh;
    logic signed [15:0] x;
    bit              neg, sat;
    out_beat_t       r;
    s = longint'(square_total);
    al = cfg_alpha[15:0];
    ah = cfg_alpha[31:16];
    weighted = (ah * s + ((al * s) >> 16)) >> 16;
    norm = longint'(cfg_kappa) + weighted;
    if (norm == 0) norm = 1;  // zero norm taken as one LSB
    e_q28 = -(longint'(cfg_beta) * log2_q16(norm));
    biased = e_q28 + (longint'(1) << 40);
    f = (biased >> 12) & 64'hFFFF;
    q = longint'(biased >> 28) - 4096;
    m = 64'd1 << 30;
    for (int b = 0; b < 16; b++)
      if ((f >> (15 - b)) & 1) m = (m * exp2_frac[b]) >> 30;
    x = sample_hist[k % WINDOW_MAX];
    neg = x < 0;
    sat = 1'b0;
    xm = neg ? longint'(-longint'(x)) : longint'(x);
    prod = xm * m;
    sh = 30 - q;
    if (prod == 0) mag = 0;
    else if (sh <= 0) begin
      mag = 0;
      sat = 1'b1;
    end else if (sh >= 64) mag = 0;
    else mag = ((prod >> (sh - 1)) + 1) >> 1;
    if (neg) begin
      if (sat || mag > 32768) begin
        mag = 32768;
        sat = 1'b1;
      end
      r.out_value = 16'(-mag);
    end else begin
      if (sat || mag > 32767) begin
        mag = 32767;
        sat = 1'b1;
      end
      r.out_value = 16'(mag);
    end
    r.saturated = sat;
    r.last_of_position = last_flag;
    return r;
  endfunction

  task automatic retire_square(int unsigned k, int unsigned lo);
    if (k >= lo) square_total = square_total - square_hist[(k - lo) % WINDOW_MAX];
  endtask

  task automatic absorb_sample(in_beat_t beat);
    int unsigned size, half, lo, i, n;
    bit          last;
    logic [31:0] sq;
    size = cfg_window;
    if (size < 1) size = 1;
    if (size > WINDOW_MAX) size = WINDOW_MAX;
    half = size / 2;
    lo = (size - 1) / 2;
    i = chan_cnt;
    n = 0;
    last = beat.last_channel || (i >= CHANNEL_MAX - 1);
    if (i >= size) square_total = square_total - square_hist[(i - size) % WINDOW_MAX];
    sq = 32'(longint'(beat.sample) * longint'(beat.sample));
    sample_hist[i % WINDOW_MAX] = beat.sample;
    square_hist[i % WINDOW_MAX] = sq;
    square_total = square_total + sq;
    if (done_cnt + half <= i) begin
      expected_norm_q.push_back(normalize_channel(done_cnt, last && done_cnt == i));
      n++;
      done_cnt++;
      if (last) retire_square(done_cnt - 1, lo);
    end
    if (last) begin
      // flush the channels still waiting on their right-hand neighbors
      while (done_cnt <= i && n < RESULT_CAP) begin
        expected_norm_q.push_back(normalize_channel(done_cnt, done_cnt == i));
        n++;
        done_cnt++;
        retire_square(done_cnt - 1, lo);
      end
      chan_cnt = 0;
      done_cnt = 0;
      square_total = '0;
    end else begin
      chan_cnt = i + 1;
    end
  endtask

  initial begin
    exp2_frac[0] = 32'(floor_sqrt(64'd1 << 61));
    for (int k = 1; k < 16; k++)
      exp2_frac[k] = 32'(floor_sqrt(longint'(exp2_frac[k-1]) << 30));
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      square_total = '0;
      chan_cnt = 0;
      done_cnt = 0;
      cfg_window = 4'd5;
      cfg_alpha = 32'd429497;
      cfg_beta = 16'd3072;
      cfg_kappa = 32'd65536;
      errors_o = 0;
      pending_o = 0;
      expected_norm_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_norm_q.size() == 0) begin
          $error("output beat with nothing expected: %p", out_beat_i);
          errors_o++;
        end else begin
          want = expected_norm_q.pop_front();
          if (out_beat_i.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", want.out_value, out_beat_i.out_value);
            errors_o++;
          end
          if (out_beat_i.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, out_beat_i.saturated);
            errors_o++;
          end
          if (out_beat_i.last_of_position !== want.last_of_position) begin
            $error("last_of_position: expected %0b, got %0b",
                   want.last_of_position, out_beat_i.last_of_position);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) absorb_sample(in_beat_i);
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_WINDOW: cfg_window = pwdata[3:0];
          REG_ALPHA:  cfg_alpha = pwdata;
          REG_BETA:   cfg_beta = pwdata[15:0];
          REG_KAPPA:  cfg_kappa = pwdata;
          default: ;
        endcase
      end
      pending_o = expected_norm_q.size();
    end
  end

endmodule

// ===== tb/sv/cross_channel_lrn_unit_tb.sv =====
// Testbench top for cross_channel_lrn_unit: clock, reset, APB setup, input
// stimulus and output back-pressure; checking is done by lrn_checker.
// Depends on lrn_pkg, lrn_checker and the block itself.
module cross_channel_lrn_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrn_pkg::*;

  localparam int IDLE_PCT   = 31;
  localparam int SETTLE_CYC = 800;
  localparam int STALL_MAX  = 5000;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid, in_ready, out_valid, out_ready;
  in_beat_t    in_beat;
  out_beat_t   out_beat;
  int          pending, errors;
  int          quiet_cyc = 0;
  bit          idle_en;

  cross_channel_lrn_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_beat_i(in_beat),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_beat_o(out_beat)
  );

  lrn_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_beat_i(in_beat),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_beat_i(out_beat),
    .pending_o(pending), .errors_o(errors)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(negedge clk_i)
    out_ready = idle_en ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;

  // watchdog: any accepted beat or register write counts as progress
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cyc <= 0;
    else
      quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= STALL_MAX) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] data);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic drain_results();
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic load_cfg(logic [3:0] w, logic [31:0] a, logic [15:0] b, logic [31:0] k);
    drain_results();
    reg_write(REG_WINDOW, {28'd0, w});
    reg_write(REG_ALPHA, a);
    reg_write(REG_BETA, {16'd0, b});
    reg_write(REG_KAPPA, k);
  endtask

  task automatic send_beat(logic signed [15:0] s, logic l);
    if (idle_en)
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid = 1'b0;
        @(negedge clk_i);
      end
    in_valid = 1'b1;
    in_beat.sample = s;
    in_beat.last_channel = l;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(511)) - 16'sd256;
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom_range(4095)) - 16'sd2048;
    endcase
  endfunction

  task automatic send_position(int len);
    for (int c = 0; c < len; c++) send_beat(pick_sample(), c == len - 1);
  endtask

  initial begin
    logic [31:0] a, k;
    logic [15:0] b;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_beat = '0;
    idle_en = 1'b1;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: field extremes under the reset settings
    send_beat(16'sh7fff, 1'b0);
    send_beat(16'sh8000, 1'b0);
    send_beat(16'sh0000, 1'b0);
    send_beat(16'sh0001, 1'b0);
    send_beat(16'shffff, 1'b0);
    send_beat(16'sh5555, 1'b1);
    send_beat(16'sh8000, 1'b1);
    // huge exponent: tiny norm raised to a large negative power
    load_cfg(4'd3, 32'd0, 16'hffff, 32'd1);
    send_beat(16'sh0100, 1'b0);
    send_beat(16'shff00, 1'b0);
    send_beat(16'sh0000, 1'b1);
    // zero norm
    load_cfg(4'd0, 32'd0, 16'd4096, 32'd0);
    send_beat(16'sh0000, 1'b0);
    send_beat(16'sh0040, 1'b1);
    // window above range, heavy alpha, max kappa
    load_cfg(4'd15, 32'hffffffff, 16'd0, 32'hffffffff);
    send_beat(16'sh7fff, 1'b0);
    send_beat(16'sh8000, 1'b0);
    send_beat(16'sh1234, 1'b1);
    // window change in the middle of a position
    load_cfg(4'd9, 32'hffffffff, 16'd6000, 32'd65536);
    send_position(0);
    for (int c = 0; c < 6; c++) send_beat(pick_sample(), 1'b0);
    load_cfg(4'd1, 32'd429497, 16'd3072, 32'd65536);
    send_beat(16'sh0200, 1'b0);
    send_beat(16'shfe00, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(2))
        0: a = 32'd0;
        1: a = 32'hffffffff;
        default: a = $urandom;
      endcase
      b = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(8192));
      k = $urandom_range(1) ? 32'($urandom_range(32'hffffffff, 1)) : 32'd65536;
      load_cfg(4'($urandom_range(15)), a, b, k);
      idle_en = (ph != 4);
      for (int n = 0; n < 52; ) begin
        int len;
        len = $urandom_range(7) == 0 ? $urandom_range(20, 1) : $urandom_range(12, 1);
        send_position(len);
        n += len;
        if ($urandom_range(9) == 0)
          while (pending != 0) @(negedge clk_i);
      end
      idle_en = 1'b1;
    end

    drain_results();
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lrn_pkg.sv
hdl/lrn_ram.sv
hdl/lrn_mul.sv
hdl/lrn_core.sv
hdl/cross_channel_lrn_unit.sv
tb/sv/lrn_checker.sv
tb/sv/cross_channel_lrn_unit_tb.sv
